// File: design/vecf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the exposed cell finder
package vecf_pkg;

	localparam int unsigned SIZE_X = 16;
	localparam int unsigned SIZE_Z = 16;
	localparam int unsigned HEIGHT = 64;

	localparam int unsigned COL_W    = 64;
	localparam int unsigned POS_W    = 4;
	// extended coordinate width, wide enough that x-1 at zero lands beyond any grid size
	localparam int unsigned EXT_W    = 8;
	localparam int unsigned DEPTH    = SIZE_X * SIZE_Z;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned PROD_W   = 2 * EXT_W;

	localparam logic [COL_W-1:0] HEIGHT_MASK = {COL_W{1'b1}} >> (COL_W - HEIGHT);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		STEP_CTR,
		STEP_XM,
		STEP_XP,
		STEP_ZM,
		STEP_ZP
	} step_t;

	typedef struct packed {
		logic  load_item;
		logic  wr_en;
		logic  rd_en;
		step_t rd_step;
		logic  out_load;
	} vecf_cmd_t;

endpackage

// File: design/vecf_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the exposed cell finder
interface vecf_req_if
	import vecf_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic             command;
	logic [POS_W-1:0] col_x;
	logic [POS_W-1:0] col_z;
	logic [COL_W-1:0] column_bits;

	modport source (output valid, command, col_x, col_z, column_bits, input ready);
	modport sink (input valid, command, col_x, col_z, column_bits, output ready);
endinterface

interface vecf_rsp_if
	import vecf_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] visible_mask;

	modport source (output valid, visible_mask, input ready);
	modport sink (input valid, visible_mask, output ready);
endinterface

// File: design/vecf_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences the five column reads of a query and the result beat
module vecf_ctrl
	import vecf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_query,
	output logic      req_ready,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output vecf_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   rsp_valid_q;
	logic   req_fire;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd.load_item = req_fire && (req_query == CMD_QUERY);
		cmd.wr_en     = req_fire && (req_query == CMD_WRITE);
		cmd.rd_en     = (state_q == S_READ);
		cmd.rd_step   = step_q;
		cmd.out_load  = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_CTR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_item) begin
						step_q  <= STEP_CTR;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					unique case (step_q)
						STEP_CTR: step_q <= STEP_XM;
						STEP_XM:  step_q <= STEP_XP;
						STEP_XP:  step_q <= STEP_ZM;
						STEP_ZM:  step_q <= STEP_ZP;
						default: begin
							step_q  <= STEP_CTR;
							state_q <= S_DRAIN;
						end
					endcase
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/vecf_dp.sv
`timescale 1ns / 1ps
// datapath: column memory with valid bits, neighbor addressing and mask logic
module vecf_dp
	import vecf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  vecf_cmd_t        cmd,
	input  logic [POS_W-1:0] col_x,
	input  logic [POS_W-1:0] col_z,
	input  logic [COL_W-1:0] column_bits,
	output logic [COL_W-1:0] visible_mask
);

	logic [COL_W-1:0]  mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	logic [EXT_W-1:0]  x_q;
	logic [EXT_W-1:0]  z_q;
	logic [EXT_W-1:0]  wr_x;
	logic [EXT_W-1:0]  wr_z;
	logic              wr_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [PROD_W-1:0] wr_lin;

	logic [EXT_W-1:0]  nx;
	logic [EXT_W-1:0]  nz;
	logic              nbr_ok;
	logic [PROD_W-1:0] rd_lin;
	logic [ADDR_W-1:0] rd_addr;

	logic              rd_en_s1;
	step_t             rd_step_s1;
	logic              nbr_ok_s1;
	logic              vld_s1;
	logic [COL_W-1:0]  rdata_s1;
	logic [COL_W-1:0]  col_data;

	logic [COL_W-1:0]  occ_q;
	logic [COL_W-1:0]  cov_q;
	logic [COL_W-1:0]  mask_q;

	assign wr_x    = EXT_W'(col_x);
	assign wr_z    = EXT_W'(col_z);
	assign wr_ok   = (32'(wr_x) < SIZE_X) && (32'(wr_z) < SIZE_Z);
	assign wr_lin  = PROD_W'(wr_x) * PROD_W'(SIZE_Z) + PROD_W'(wr_z);
	assign wr_addr = wr_lin[ADDR_W-1:0];

	// neighbor coordinates; x-1 at zero wraps high and fails the range check
	always_comb begin
		nx = x_q;
		nz = z_q;
		unique case (cmd.rd_step)
			STEP_CTR: ;
			STEP_XM:  nx = x_q - EXT_W'(1);
			STEP_XP:  nx = x_q + EXT_W'(1);
			STEP_ZM:  nz = z_q - EXT_W'(1);
			STEP_ZP:  nz = z_q + EXT_W'(1);
			default: ;
		endcase
	end

	assign nbr_ok  = (32'(nx) < SIZE_X) && (32'(nz) < SIZE_Z);
	assign rd_lin  = PROD_W'(nx) * PROD_W'(SIZE_Z) + PROD_W'(nz);
	assign rd_addr = rd_lin[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[wr_addr] <= column_bits & HEIGHT_MASK;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_en_s1   <= 1'b0;
			rd_step_s1 <= STEP_CTR;
			nbr_ok_s1  <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			if (cmd.wr_en && wr_ok) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_en_s1   <= cmd.rd_en;
			rd_step_s1 <= cmd.rd_step;
			nbr_ok_s1  <= nbr_ok;
			vld_s1     <= vld_q[rd_addr];
		end
	end

	// never-written columns and columns off the grid read as empty
	assign col_data = (nbr_ok_s1 && vld_s1) ? rdata_s1 : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q   <= wr_x;
			z_q   <= wr_z;
			cov_q <= '1;
		end else if (rd_en_s1) begin
			if (rd_step_s1 == STEP_CTR) begin
				occ_q <= col_data;
			end else begin
				cov_q <= cov_q & col_data;
			end
		end
		if (cmd.out_load) begin
			mask_q <= occ_q & ~(cov_q & (occ_q >> 1) & (occ_q << 1)) & HEIGHT_MASK;
		end
	end

	assign visible_mask = mask_q;

endmodule

// File: design/voxel_exposed_cell_finder_top.sv
`timescale 1ns / 1ps
// Exposed cell finder: keeps a SIZE_X by SIZE_Z grid of HEIGHT-cell voxel columns
// and returns, for a queried column, the occupied cells that have at least one
// empty face neighbor (off-grid neighbors count as empty). A write beat stores a
// column as it is accepted and gives no response; writes off the grid are dropped.
// For a query beat the center column and its four horizontal neighbors are read
// one per cycle from the single read port of the column memory, then a drain state
// lets the last read land and a finish state loads the response register, once the
// previous response is taken, before the next beat can be accepted. A finished
// response waits in its own register, so the next beat is taken while it is still
// pending. The store reads as empty after reset through per-column valid bits, with no clearing pass.
module voxel_exposed_cell_finder_top
	import vecf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	vecf_req_if.sink  req,
	vecf_rsp_if.source rsp
);

	vecf_cmd_t cmd;

	vecf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_query (req.command),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	vecf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.col_x        (req.col_x),
		.col_z        (req.col_z),
		.column_bits  (req.column_bits),
		.visible_mask (rsp.visible_mask)
	);

endmodule

// File: design/vecf_checker.sv
`timescale 1ns / 1ps
// port-level checker of the exposed cell finder and its bind
module vecf_checker
	import vecf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_command,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [COL_W-1:0] rsp_visible_mask
);

	logic req_fire;
	assign req_fire = req_valid && req_ready;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible_mask))
		else $error("response changed while stalled");

	// no beat ever produces a response in the very next cycle
	a_no_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && !rsp_valid |=> !rsp_valid)
		else $error("response appeared one cycle after a request");

	// a query blocks the request side while its reads run
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req_command == CMD_QUERY) |=> !req_ready)
		else $error("request taken during a query");

	// a response is only launched from the busy phase
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response raised while idle");

endmodule

bind voxel_exposed_cell_finder_top vecf_checker u_vecf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_command      (req.command),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_visible_mask (rsp.visible_mask)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench of the exposed cell finder: random writes and queries checked against a column model
module tb;
	import vecf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RANDOM_BEATS = 1700;

	// keeps its own copy of the occupancy grid and the visible masks still to come
	class column_mask_board;
		logic [COL_W-1:0] occ_grid [SIZE_X][SIZE_Z];
		logic [COL_W-1:0] mask_q [$];
		int               bad_count;

		function new();
			foreach (occ_grid[i, j]) occ_grid[i][j] = '0;
			bad_count = 0;
		endfunction

		// off-grid neighbors read as empty
		function logic [COL_W-1:0] column_or_air(int x, int z);
			if (x < 0 || z < 0 || x >= int'(SIZE_X) || z >= int'(SIZE_Z)) return '0;
			return occ_grid[x][z];
		endfunction

		function logic [COL_W-1:0] exposed_cells(int x, int z);
			logic [COL_W-1:0] occ;
			logic [COL_W-1:0] covered;
			if (x >= int'(SIZE_X) || z >= int'(SIZE_Z)) return '0;
			occ = occ_grid[x][z];
			covered = column_or_air(x - 1, z) & column_or_air(x + 1, z)
				& column_or_air(x, z - 1) & column_or_air(x, z + 1)
				& (occ >> 1) & (occ << 1);
			return occ & ~covered & HEIGHT_MASK;
		endfunction

		function void take_beat(logic cmd, logic [POS_W-1:0] x, logic [POS_W-1:0] z,
				logic [COL_W-1:0] bits);
			if (cmd == CMD_WRITE) begin
				if (x < SIZE_X && z < SIZE_Z) occ_grid[x][z] = bits & HEIGHT_MASK;
			end else begin
				mask_q.push_back(exposed_cells(int'(x), int'(z)));
			end
		endfunction

		function void check_mask(logic [COL_W-1:0] actual);
			logic [COL_W-1:0] expected;
			if (mask_q.size() == 0) begin
				if (bad_count < 10)
					$display("mismatch: unexpected response visible_mask=%h", actual);
				bad_count++;
				return;
			end
			expected = mask_q.pop_front();
			if (actual !== expected) begin
				if (bad_count < 10)
					$display("mismatch: visible_mask expected %h actual %h", expected, actual);
				bad_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int unsigned cycles;
	column_mask_board board;

	vecf_req_if req_ch ();
	vecf_rsp_if rsp_ch ();

	voxel_exposed_cell_finder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, a few long ones, none during calm stretches
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// dense columns so that interior cells really get covered
	function automatic logic [COL_W-1:0] pick_column();
		int r;
		logic [COL_W-1:0] v;
		r = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (r < 35) return '1;
		if (r < 60) return ~((COL_W'(1) << $urandom_range(0, COL_W - 1)) |
			(COL_W'(1) << $urandom_range(0, COL_W - 1)));
		if (r < 80) return v;
		if (r < 90) return '0;
		return v | {$urandom, $urandom};
	endfunction

	task automatic send_beat(input logic cmd, input int x, input int z,
			input logic [COL_W-1:0] bits);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.command     = cmd;
		req_ch.col_x       = POS_W'(x);
		req_ch.col_z       = POS_W'(z);
		req_ch.column_bits = bits;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_col(input int x, input int z, input logic [COL_W-1:0] bits);
		send_beat(CMD_WRITE, x, z, bits);
	endtask

	task automatic query_col(input int x, input int z);
		send_beat(CMD_QUERY, x, z, {$urandom, $urandom});
	endtask

	// beats are taken on the rising edge, responses checked before the same edge's beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) board.check_mask(rsp_ch.visible_mask);
			if (req_ch.valid && req_ch.ready)
				board.take_beat(req_ch.command, req_ch.col_x, req_ch.col_z,
					req_ch.column_bits);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL voxel_exposed_cell_finder_top");
			$finish;
		end
	end

	// response side: runs of ready separated by stalls
	initial begin
		int run;
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				rsp_ch.ready = 1'b1;
			end
			stall = idle_cycles();
			repeat (stall) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
			end
		end
	end

	initial begin
		int base_x;
		int base_z;
		int x;
		int z;
		board = new();
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_WRITE;
		req_ch.col_x = '0;
		req_ch.col_z = '0;
		req_ch.column_bits = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty store after reset, then full columns on corners
		query_col(0, 0);
		write_col(0, 0, '1);
		query_col(0, 0);
		write_col(SIZE_X - 1, SIZE_Z - 1, '1);
		query_col(SIZE_X - 1, SIZE_Z - 1);
		// fully surrounded column: only the top and bottom cells stay exposed
		write_col(5, 5, '1);
		write_col(4, 5, '1);
		write_col(6, 5, '1);
		write_col(5, 4, '1);
		write_col(5, 6, '1);
		query_col(5, 5);
		// empty cells are never visible
		write_col(5, 5, '0);
		query_col(5, 5);
		write_col(5, 5, {(COL_W / 2){2'b10}});
		query_col(5, 5);
		write_col(0, SIZE_Z - 1, COL_W'(1) << (HEIGHT - 1));
		query_col(0, SIZE_Z - 1);
		write_col(SIZE_X - 1, 0, COL_W'(1));
		query_col(SIZE_X - 1, 0);
		query_col(4, 5);

		base_x = 0;
		base_z = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						base_x = 0;
						base_z = SIZE_Z - 4;
					end
					1: begin
						base_x = SIZE_X - 4;
						base_z = 0;
					end
					default: begin
						base_x = $urandom_range(0, SIZE_X - 4);
						base_z = $urandom_range(0, SIZE_Z - 4);
					end
				endcase
			end
			// most beats stay in a small window so neighbors get filled in
			if ($urandom_range(0, 9) < 7) begin
				x = base_x + $urandom_range(0, 3);
				z = base_z + $urandom_range(0, 3);
			end else begin
				x = $urandom_range(0, SIZE_X - 1);
				z = $urandom_range(0, SIZE_Z - 1);
			end
			if ($urandom_range(0, 1) == 0) write_col(x, z, pick_column());
			else query_col(x, z);
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (board.mask_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.bad_count == 0) begin
			$display("PASS voxel_exposed_cell_finder_top");
		end else begin
			$display("FAIL voxel_exposed_cell_finder_top");
		end
		$finish;
	end

endmodule
